// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the allocator RTL.
// Depends on nothing; compiled away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check prop at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check cons in the cycle after ante, outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- hdl/tfra_pkg.sv -----
// Types, constants and placement helpers of the transmit frame ring allocator.
// Depends on nothing.
package tfra_pkg;

   localparam int DESC_COUNT = 256;
   localparam int LINE_BYTES = 64;   // power of two
   localparam int HDR_BYTES  = 18;

   localparam int IDX_W  = $clog2(DESC_COUNT);
   localparam int CNT_W  = $clog2(DESC_COUNT + 1);
   localparam int POS_W  = 24;
   localparam int LEN_W  = 16;
   localparam int FB_W   = LEN_W + 1;
   localparam int MTU2_W = FB_W + 1;

   localparam logic [POS_W-1:0] RING_RESET = POS_W'(65536);
   localparam logic [LEN_W-1:0] MTU_RESET  = LEN_W'(1500);

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_BUSY         = 3'd1,
      ST_BAD_USED     = 3'd2,
      ST_BAD_DESC     = 3'd3,
      ST_POS_MISMATCH = 3'd4,
      ST_OVERFREE     = 3'd5
   } status_type;

   typedef enum logic {
      CMD_ALLOC   = 1'b0,
      CMD_RELEASE = 1'b1
   } cmd_type;

   typedef enum logic {
      REG_RING_SIZE = 1'b0,
      REG_MTU       = 1'b1
   } reg_type;

   typedef struct packed {
      logic [POS_W-1:0] start;
      logic [POS_W-1:0] nxt;
   } place_type;

   // Header plus payload, rounded up to whole lines.
   function automatic logic [FB_W-1:0] frame_bytes(input logic [LEN_W-1:0] len);
      logic [FB_W-1:0] raw;
      raw = FB_W'(HDR_BYTES) + FB_W'(len) + FB_W'(LINE_BYTES - 1);
      return raw & ~FB_W'(LINE_BYTES - 1);
   endfunction

   function automatic logic [POS_W-1:0] room_before_end(input logic [POS_W-1:0] pos,
                                                        input logic [POS_W-1:0] ring);
      return (pos >= ring) ? '0 : ring - pos;
   endfunction

   // Largest contiguous free run between head and tail.
   function automatic logic [POS_W-1:0] space_now(input logic [POS_W-1:0] head,
                                                  input logic [POS_W-1:0] tail,
                                                  input logic [POS_W-1:0] ring);
      logic [POS_W-1:0] room;
      room = room_before_end(head, ring);
      if (head < tail) begin
         return tail - head;
      end
      return (room > tail) ? room : tail;
   endfunction

   // Wrap to offset 0 when the frame does not fit before the ring end.
   function automatic place_type place(input logic [POS_W-1:0] pos,
                                       input logic [FB_W-1:0]  fs,
                                       input logic [POS_W-1:0] ring);
      place_type r;
      r.start = (room_before_end(pos, ring) < POS_W'(fs)) ? '0 : pos;
      r.nxt   = r.start + POS_W'(fs);
      return r;
   endfunction

endpackage

// ----- hdl/tx_frame_ring_allocator_core.sv -----
// Transmit frame ring allocator: input register, one pass of placement logic,
// result register. Depends on tfra_pkg and assert_macros.svh.
// Each accepted item waits in the input register until the result register is free or
// draining; its result is then registered. Throughput: one item per cycle while the result
// is not stalled; a stalled result holds the item in the input register.
// Reset (synchronous): ring empty, all descriptors free, ring_size 65536, mtu 1500.
`include "assert_macros.svh"

module tx_frame_ring_allocator_core
   import tfra_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,   // frame_len, used_id, used_len, desc_flags, data_offset
   input  logic [0:0]  req_tuser,   // cmd
   // response
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // desc_index, frame_offset, can_send, free_descs, free_space
   output logic [2:0]  rsp_tuser,   // status
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // ---------------- configuration registers ----------------
   logic [POS_W-1:0]  ring_ff;
   logic [LEN_W-1:0]  mtu_ff;
   logic [MTU2_W-1:0] mtu2_ff;      // twice the aligned frame size of mtu
   logic              csr_wr;
   reg_type           csr_reg;

   assign csr_pready = 1'b1;
   assign csr_reg    = reg_type'(csr_paddr[2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_reg)
         REG_RING_SIZE: csr_prdata = {8'd0, ring_ff};
         REG_MTU:       csr_prdata = {16'd0, mtu_ff};
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_ff <= RING_RESET;
         mtu_ff  <= MTU_RESET;
         mtu2_ff <= {frame_bytes(MTU_RESET), 1'b0};
      end else if (csr_wr) begin
         case (csr_reg)
            REG_RING_SIZE: ring_ff <= csr_pwdata[POS_W-1:0];
            REG_MTU: begin
               mtu_ff  <= csr_pwdata[LEN_W-1:0];
               mtu2_ff <= {frame_bytes(csr_pwdata[LEN_W-1:0]), 1'b0};
            end
            default: ;
         endcase
      end
   end

   // ---------------- input register ----------------
   logic             in_valid_ff;
   cmd_type          in_cmd_ff;
   logic [LEN_W-1:0] in_flen_ff;
   logic [LEN_W-1:0] in_uid_ff;
   logic [LEN_W-1:0] in_ulen_ff;
   logic [LEN_W-1:0] in_flags_ff;
   logic [POS_W-1:0] in_doff_ff;
   logic             rsp_valid_ff;
   logic             proc_fire;
   logic             req_fire;

   // Process the held item whenever the result register is free or draining.
   assign proc_fire  = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || proc_fire;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_cmd_ff   <= cmd_type'(req_tuser[0]);
         in_flen_ff  <= req_tdata[15:0];
         in_uid_ff   <= req_tdata[31:16];
         in_ulen_ff  <= req_tdata[47:32];
         in_flags_ff <= req_tdata[63:48];
         in_doff_ff  <= req_tdata[87:64];
      end
   end

   // ---------------- allocator state ----------------
   logic [POS_W-1:0] head_ff, head_in;
   logic [POS_W-1:0] tail_ff, tail_in;
   logic [IDX_W-1:0] top_ff, top_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Free-list link memory; an entry never written reads as its reset link.
   logic [IDX_W-1:0] link_mem [DESC_COUNT];
   logic [DESC_COUNT-1:0] link_valid_ff;
   logic [IDX_W-1:0] link_q_ff;        // registered memory read
   logic             link_vq_ff;       // valid bit of that entry
   logic [IDX_W-1:0] link_aq_ff;       // address of that read
   logic             link_byp_ff;      // last step pushed: link is byp value
   logic [IDX_W-1:0] link_byp_val_ff;
   logic [IDX_W-1:0] top_link;         // next_link[top_ff]

   always_comb begin
      if (link_byp_ff) begin
         top_link = link_byp_val_ff;
      end else if (link_vq_ff) begin
         top_link = link_q_ff;
      end else if (link_aq_ff == IDX_W'(DESC_COUNT - 1)) begin
         top_link = '0;
      end else begin
         top_link = link_aq_ff + IDX_W'(1);
      end
   end

   // ---------------- single-pass step logic ----------------
   logic [FB_W-1:0]  fs;
   logic [POS_W-1:0] space_cur;
   logic             alloc_ok;
   place_type        plc_head;
   place_type        plc_tail;
   status_type       rel_status;
   logic             rel_ok;
   status_type       status_in;
   logic [IDX_W-1:0] idx_in;
   logic [POS_W-1:0] off_in;
   logic [POS_W-1:0] space_nx;
   logic             can_nx;

   always_comb begin
      fs        = frame_bytes(in_flen_ff);
      space_cur = space_now(head_ff, tail_ff, ring_ff);
      alloc_ok  = (count_ff >= CNT_W'(2)) && (space_cur >= POS_W'(mtu2_ff));
      plc_head  = place(head_ff, fs, ring_ff);
      plc_tail  = place(tail_ff, fs, ring_ff);

      // Release checks, first failure wins.
      if (in_uid_ff >= LEN_W'(DESC_COUNT) || in_ulen_ff != LEN_W'(1)) begin
         rel_status = ST_BAD_USED;
      end else if (in_flags_ff != '0 || in_doff_ff >= ring_ff ||
                   POS_W'(in_flen_ff) > ring_ff - in_doff_ff) begin
         rel_status = ST_BAD_DESC;
      end else if (in_doff_ff != plc_tail.start) begin
         rel_status = ST_POS_MISMATCH;
      end else if (count_ff >= CNT_W'(DESC_COUNT)) begin
         rel_status = ST_OVERFREE;
      end else begin
         rel_status = ST_OK;
      end
      rel_ok = (in_cmd_ff == CMD_RELEASE) && (rel_status == ST_OK);

      // Hold state unless the step succeeds.
      head_in   = head_ff;
      tail_in   = tail_ff;
      top_in    = top_ff;
      count_in  = count_ff;
      idx_in    = '0;
      off_in    = '0;
      status_in = ST_OK;
      case (in_cmd_ff)
         CMD_ALLOC: begin
            if (alloc_ok) begin
               idx_in   = top_ff;
               off_in   = plc_head.start;
               head_in  = plc_head.nxt;
               top_in   = top_link;
               count_in = count_ff - CNT_W'(1);
            end else begin
               status_in = ST_BUSY;
            end
         end
         CMD_RELEASE: begin
            status_in = rel_status;
            if (rel_ok) begin
               tail_in  = plc_tail.nxt;
               top_in   = in_uid_ff[IDX_W-1:0];
               count_in = count_ff + CNT_W'(1);
            end
         end
         default: status_in = ST_BUSY;
      endcase

      // Report on the state after this step.
      space_nx = space_now(head_in, tail_in, ring_ff);
      can_nx   = (count_in >= CNT_W'(2)) && (space_nx >= POS_W'(mtu2_ff));
   end

   // Advance state only for the item being processed.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff         <= '0;
         tail_ff         <= '0;
         top_ff          <= '0;
         count_ff        <= CNT_W'(DESC_COUNT);
         link_valid_ff   <= '0;
         link_vq_ff      <= 1'b0;
         link_aq_ff      <= '0;
         link_byp_ff     <= 1'b0;
      end else begin
         if (proc_fire) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            top_ff   <= top_in;
            count_ff <= count_in;
            if (rel_ok) begin
               link_valid_ff[in_uid_ff[IDX_W-1:0]] <= 1'b1;
            end
         end
         // Prefetch the link of the list head for the next cycle.
         link_vq_ff  <= link_valid_ff[proc_fire ? top_in : top_ff];
         link_aq_ff  <= proc_fire ? top_in : top_ff;
         link_byp_ff <= proc_fire && rel_ok;
      end
   end

   // Link memory: one write, one registered read per cycle.
   always_ff @(posedge clock) begin
      if (proc_fire && rel_ok) begin
         link_mem[in_uid_ff[IDX_W-1:0]] <= top_ff;
      end
      link_q_ff       <= link_mem[proc_fire ? top_in : top_ff];
      link_byp_val_ff <= top_ff;
   end

   // ---------------- result register ----------------
   status_type       rsp_status_ff;
   logic [IDX_W-1:0] rsp_idx_ff;
   logic [POS_W-1:0] rsp_off_ff;
   logic             rsp_can_ff;
   logic [CNT_W-1:0] rsp_count_ff;
   logic [POS_W-1:0] rsp_space_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (proc_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proc_fire) begin
         rsp_status_ff <= status_in;
         rsp_idx_ff    <= idx_in;
         rsp_off_ff    <= off_in;
         rsp_can_ff    <= can_nx;
         rsp_count_ff  <= count_in;
         rsp_space_ff  <= space_nx;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {6'd0, rsp_space_ff, rsp_count_ff, rsp_can_ff,
                        rsp_off_ff, rsp_idx_ff};

   // ---------------- assertions ----------------
   `ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= CNT_W'(DESC_COUNT),
                  "free count above pool size")
   `ASSERT_NEXT(a_alloc_pop, clock, reset, proc_fire && in_cmd_ff == CMD_ALLOC && alloc_ok,
                count_ff == $past(count_ff) - CNT_W'(1), "allocate did not take a descriptor")
   `ASSERT_NEXT(a_fail_hold, clock, reset, proc_fire && status_in != ST_OK,
                $stable(head_ff) && $stable(tail_ff) && $stable(top_ff) && $stable(count_ff),
                "refused item changed state")
   `ASSERT_NEXT(a_release_push, clock, reset, proc_fire && rel_ok,
                top_link == $past(top_ff), "pushed descriptor lost its link")

endmodule
